FILE: rtl/core/vd3_pkg.sv
`timescale 1ns / 1ps
package vd3_pkg;
	localparam int NgbMax = 64;
	localparam int AddrW = $clog2(NgbMax);
	localparam int CntW = $clog2(NgbMax + 1);
	localparam int SumW = 16 + CntW;
	localparam int SqW = 32 + CntW;
	localparam int SsW = 32 + CntW;
	localparam int TotW = 2 * SumW + 2;
	localparam int DistW = 18 + CntW;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RD,
		ST_ACC,
		ST_SQRT,
		ST_VAR,
		ST_DIV,
		ST_RSQRT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clr_acc;
		logic rd_en;
		logic acc_en;
		logic sqrt_start;
		logic var_start;
		logic div_start;
		logic rsqrt_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic var_done;
		logic div_done;
		logic rsqrt_done;
		logic rd_last;
	} sts_t;
endpackage

FILE: rtl/core/vd3_sqrt.sv
`timescale 1ns / 1ps
// restoring square root, one result bit per cycle
module vd3_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [vd3_pkg::TotW-1:0]      radicand,
	output logic                          done,
	output logic [vd3_pkg::TotW/2-1:0]    root
);
	localparam int W = vd3_pkg::TotW;
	localparam int RW = W / 2;
	localparam int StW = $clog2(RW + 1);

	logic [W-1:0]   rem_q;
	logic [W-1:0]   val_q;
	logic [RW-1:0]  root_q;
	logic [StW-1:0] cnt_q;
	logic           busy_q;
	logic [W+1:0]   trial;
	logic [W+1:0]   cur;

	assign cur   = {rem_q, val_q[W-1 -: 2]};
	assign trial = cur - {{(W - RW){1'b0}}, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= StW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == StW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			val_q  <= radicand;
			root_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[W-3:0], 2'b00};
			if (!trial[W+1]) begin
				rem_q  <= trial[W-1:0];
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= cur[W-1:0];
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

FILE: rtl/core/vd3_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module vd3_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [vd3_pkg::TotW-1:0]   dividend,
	input  logic [2*vd3_pkg::CntW-1:0] divisor,
	output logic                       done,
	output logic [vd3_pkg::TotW-1:0]   quot
);
	localparam int W = vd3_pkg::TotW;
	localparam int DW = 2 * vd3_pkg::CntW;
	localparam int StW = $clog2(W + 1);

	logic [W-1:0]   q_q;
	logic [DW:0]    r_q;
	logic [DW-1:0]  d_q;
	logic [StW-1:0] cnt_q;
	logic           busy_q;
	logic [DW+1:0]  sh;
	logic [DW+1:0]  diff;

	assign sh   = {r_q, q_q[W-1]};
	assign diff = sh - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= StW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == StW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DW+1]) begin
				r_q <= diff[DW:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= sh[DW:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule

FILE: rtl/core/vd3_ctrl.sv
`timescale 1ns / 1ps
module vd3_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_xfer,
	input  logic          in_last,
	input  logic          out_free,
	input  vd3_pkg::sts_t sts,
	output vd3_pkg::cmd_t cmd,
	output logic          busy
);
	vd3_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= vd3_pkg::ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			vd3_pkg::ST_LOAD: begin
				busy = 1'b0;
				if (in_xfer && in_last) begin
					state_d = vd3_pkg::ST_RD;
					cmd.clr_acc = 1'b1;
				end
			end
			vd3_pkg::ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d = vd3_pkg::ST_ACC;
			end
			vd3_pkg::ST_ACC: begin
				cmd.acc_en = 1'b1;
				cmd.sqrt_start = 1'b1;
				state_d = vd3_pkg::ST_SQRT;
			end
			vd3_pkg::ST_SQRT: begin
				if (sts.sqrt_done) begin
					if (sts.rd_last) begin
						cmd.var_start = 1'b1;
						state_d = vd3_pkg::ST_VAR;
					end else state_d = vd3_pkg::ST_RD;
				end
			end
			vd3_pkg::ST_VAR: begin
				if (sts.var_done) begin
					cmd.div_start = 1'b1;
					state_d = vd3_pkg::ST_DIV;
				end
			end
			vd3_pkg::ST_DIV: begin
				if (sts.div_done) begin
					cmd.rsqrt_start = 1'b1;
					state_d = vd3_pkg::ST_RSQRT;
				end
			end
			vd3_pkg::ST_RSQRT: begin
				if (sts.rsqrt_done) state_d = vd3_pkg::ST_OUT;
			end
			vd3_pkg::ST_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = vd3_pkg::ST_LOAD;
				end
			end
			default: state_d = vd3_pkg::ST_LOAD;
		endcase
	end
endmodule

FILE: rtl/core/vd3_dp.sv
`timescale 1ns / 1ps
module vd3_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_xfer,
	input  logic [15:0]            vx,
	input  logic [15:0]            vy,
	input  logic [15:0]            vz,
	input  vd3_pkg::cmd_t          cmd,
	output vd3_pkg::sts_t          sts,
	output logic [31:0]            res_sqx,
	output logic [31:0]            res_sqy,
	output logic [31:0]            res_sqz,
	output logic [16:0]            res_dist,
	output logic [16:0]            res_rad,
	output logic [6:0]             res_cnt,
	output logic                   res_ovf
);
	localparam int AW = vd3_pkg::AddrW;
	localparam int CW = vd3_pkg::CntW;
	localparam int SW = vd3_pkg::SumW;
	localparam int QW = vd3_pkg::SqW;
	localparam int TW = vd3_pkg::TotW;
	localparam int DW = vd3_pkg::DistW;
	localparam int VW = 2 * SW + CW + 1;

	logic [47:0] mem [vd3_pkg::NgbMax];
	logic [47:0] rd_s1;
	logic [CW-1:0] cnt_q, n_q, idx_q;
	logic signed [SW-1:0] sx_q, sy_q, sz_q;
	logic ovf_q, ovf_n_q;
	logic signed [15:0] x0_q, y0_q, z0_q;
	logic [QW-1:0] sqx_q, sqy_q, sqz_q, ssx_q, ssy_q, ssz_q;
	logic [DW-1:0] dist_q;
	logic [31:0] ex_s2, ey_s2, ez_s2, xx_s2, yy_s2, zz_s2;
	logic [TW-1:0] sq_in;
	logic sq_start, sq_done;
	logic [TW/2-1:0] sq_root;
	logic [1:0] ph_q;
	logic var_busy_q, var_done_q;
	logic [TW-1:0] tot_q;
	logic [TW-1:0] div_in, div_q;
	logic [TW-1:0] quot;
	logic div_done;
	logic [2*CW-1:0] nn;
	logic rad_ph_q;
	logic [TW-1:0] n_div_in;
	logic signed [16:0] dx, dy, dz;
	logic signed [15:0] rx, ry, rz;

	// sample load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.out_load) begin
			cnt_q <= '0;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
			ovf_q <= 1'b0;
		end else if (in_xfer) begin
			if (cnt_q < CW'(vd3_pkg::NgbMax)) begin
				cnt_q <= cnt_q + 1'b1;
				sx_q <= sx_q + SW'(signed'(vx));
				sy_q <= sy_q + SW'(signed'(vy));
				sz_q <= sz_q + SW'(signed'(vz));
			end else ovf_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && cnt_q < CW'(vd3_pkg::NgbMax))
			mem[cnt_q[AW-1:0]] <= {vz, vy, vx};
		if (cmd.rd_en) rd_s1 <= mem[idx_q[AW-1:0]];
	end

	assign rx = signed'(rd_s1[15:0]);
	assign ry = signed'(rd_s1[31:16]);
	assign rz = signed'(rd_s1[47:32]);
	assign dx = 17'(x0_q) - 17'(rx);
	assign dy = 17'(y0_q) - 17'(ry);
	assign dz = 17'(z0_q) - 17'(rz);

	// second pass over the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			n_q <= '0;
			ovf_n_q <= 1'b0;
		end else if (cmd.clr_acc) begin
			idx_q <= '0;
			n_q <= (cnt_q < CW'(vd3_pkg::NgbMax)) ? cnt_q + 1'b1 : cnt_q;
			// a last sample that finds the store full is dropped too
			ovf_n_q <= ovf_q || (cnt_q == CW'(vd3_pkg::NgbMax));
		end else if (cmd.rd_en) idx_q <= idx_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			sqx_q <= '0; sqy_q <= '0; sqz_q <= '0;
			ssx_q <= '0; ssy_q <= '0; ssz_q <= '0;
			dist_q <= '0;
		end
		if (cmd.acc_en) begin
			if (idx_q == CW'(1)) begin
				x0_q <= rx; y0_q <= ry; z0_q <= rz;
			end
			ex_s2 <= (idx_q == CW'(1)) ? 32'd0 : 32'(dx * dx);
			ey_s2 <= (idx_q == CW'(1)) ? 32'd0 : 32'(dy * dy);
			ez_s2 <= (idx_q == CW'(1)) ? 32'd0 : 32'(dz * dz);
			xx_s2 <= 32'(rx * rx);
			yy_s2 <= 32'(ry * ry);
			zz_s2 <= 32'(rz * rz);
		end
		if (sq_start) begin
			sqx_q <= sqx_q + QW'(ex_s2);
			sqy_q <= sqy_q + QW'(ey_s2);
			sqz_q <= sqz_q + QW'(ez_s2);
			ssx_q <= ssx_q + QW'(xx_s2);
			ssy_q <= ssy_q + QW'(yy_s2);
			ssz_q <= ssz_q + QW'(zz_s2);
		end
		if (sq_done && !rad_ph_q) dist_q <= dist_q + DW'(sq_root);
	end

	logic sq_go_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_go_q <= 1'b0;
		else sq_go_q <= cmd.sqrt_start;
	end
	assign sq_start = sq_go_q || cmd.rsqrt_start;
	// the final root reads the tot/n^2 quotient held in div_q
	assign sq_in = cmd.rsqrt_start ? div_q
		: TW'(ex_s2) + TW'(ey_s2) + TW'(ez_s2);

	// rad_ph marks the final root over the dispersion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rad_ph_q <= 1'b0;
		else if (cmd.rsqrt_start) rad_ph_q <= 1'b1;
		else if (cmd.out_load) rad_ph_q <= 1'b0;
	end

	vd3_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_in),
		.done(sq_done), .root(sq_root)
	);

	// per axis numerator n*ss - s^2, the three axes taken one after another
	logic signed [SW-1:0] s_sel;
	logic [QW-1:0] ss_sel;
	logic signed [VW-1:0] mp_s1, sq_s1;
	logic [2:0] vcnt_q;
	always_comb begin
		case (ph_q)
			2'd0: begin s_sel = sx_q; ss_sel = ssx_q; end
			2'd1: begin s_sel = sy_q; ss_sel = ssy_q; end
			default: begin s_sel = sz_q; ss_sel = ssz_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_busy_q <= 1'b0;
			var_done_q <= 1'b0;
			ph_q <= '0;
			vcnt_q <= '0;
		end else begin
			var_done_q <= 1'b0;
			if (cmd.var_start) begin
				var_busy_q <= 1'b1;
				ph_q <= '0;
				vcnt_q <= '0;
			end else if (var_busy_q) begin
				vcnt_q <= vcnt_q + 1'b1;
				if (vcnt_q < 3'd2) ph_q <= ph_q + 1'b1;
				if (vcnt_q == 3'd3) begin
					var_busy_q <= 1'b0;
					var_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.var_start) tot_q <= '0;
		if (var_busy_q && vcnt_q < 3'd3) begin
			mp_s1 <= VW'(signed'({1'b0, n_q})) * VW'(signed'({1'b0, ss_sel}));
			sq_s1 <= VW'(s_sel) * VW'(s_sel);
		end
		if (var_busy_q && vcnt_q != 3'd0) begin
			if (mp_s1 > sq_s1) tot_q <= tot_q + TW'(mp_s1 - sq_s1);
		end
	end

	// divider shared by the five quotients
	logic [2:0] dcnt_q;
	logic dbusy_q, dstart, ddone_q;
	logic [TW-1:0] qx_q, qy_q, qz_q, qd_q;
	assign nn = (dcnt_q == 3'd0) ? (2*CW)'(n_q) * (2*CW)'(n_q) : (2*CW)'(n_q);
	always_comb begin
		case (dcnt_q)
			3'd0: div_in = tot_q;
			3'd1: div_in = TW'(sqx_q);
			3'd2: div_in = TW'(sqy_q);
			3'd3: div_in = TW'(sqz_q);
			default: div_in = TW'(dist_q);
		endcase
	end
	assign n_div_in = div_in;
	logic dgo_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0; dbusy_q <= 1'b0; ddone_q <= 1'b0; dgo_q <= 1'b0;
		end else begin
			ddone_q <= 1'b0;
			dgo_q <= 1'b0;
			if (cmd.div_start) begin
				dcnt_q <= '0; dbusy_q <= 1'b1; dgo_q <= 1'b1;
			end else if (dbusy_q && div_done) begin
				if (dcnt_q == 3'd4) begin
					dbusy_q <= 1'b0; ddone_q <= 1'b1;
				end else begin
					dcnt_q <= dcnt_q + 1'b1; dgo_q <= 1'b1;
				end
			end
		end
	end
	assign dstart = dgo_q;

	vd3_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(n_div_in),
		.divisor(nn), .done(div_done), .quot(quot)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (dcnt_q)
				3'd0: div_q <= quot;
				3'd1: qx_q <= quot;
				3'd2: qy_q <= quot;
				3'd3: qz_q <= quot;
				default: qd_q <= quot;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_sqx <= qx_q[31:0];
			res_sqy <= qy_q[31:0];
			res_sqz <= qz_q[31:0];
			res_dist <= qd_q[16:0];
			res_rad <= 17'(sq_root);
			res_cnt <= 7'(n_q);
			res_ovf <= ovf_n_q;
		end
	end

	assign sts.sqrt_done = sq_done;
	assign sts.var_done = var_done_q;
	assign sts.div_done = ddone_q;
	assign sts.rsqrt_done = sq_done && rad_ph_q;
	assign sts.rd_last = (idx_q == n_q);
endmodule

FILE: rtl/core/velocity_dispersion_3d.sv
`timescale 1ns / 1ps
// velocity_dispersion_3d: dispersion statistics over a set of 3d velocity samples
// input channel s_axis: one sample per transfer, tlast marks the final sample
// of a set; samples past the 64-entry store are dropped and flagged
// output channel m_axis: one result transfer per set, held until taken
// a non-last sample is taken as soon as it is offered, one per cycle
// after the last sample the block walks the store again: per sample one
// memory read, one set of squares and a serial square root, then three
// variance terms, five serial divides and one final root
// the serial divider and root unit set the latency
// s_axis_tready is low from the last sample until the result is registered
// a stalled receiver holds the result; the next set loads but its result waits
// reset clears the count, sums and flags; the store needs no clearing
module velocity_dispersion_3d (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // vel_x, vel_y, vel_z
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// mean_sq_dev_x, mean_sq_dev_y, mean_sq_dev_z, mean_dist_from_first,
	// radial_dispersion, sample_count, overflow, zero fill
	output logic [143:0] m_axis_tdata
);
	vd3_pkg::cmd_t cmd;
	vd3_pkg::sts_t sts;
	logic busy, in_xfer, out_free;
	logic [31:0] sqx, sqy, sqz;
	logic [16:0] mean_dist, rad;
	logic [6:0] cnt;
	logic ovf;
	logic valid_q;

	assign s_axis_tready = !busy;
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign out_free = !valid_q || m_axis_tready;

	// result register holds one finished transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (cmd.out_load) valid_q <= 1'b1;
		else if (m_axis_tready) valid_q <= 1'b0;
	end
	assign m_axis_tvalid = valid_q;

	vd3_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_xfer(in_xfer), .in_last(s_axis_tlast),
		.out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy)
	);

	vd3_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_xfer(in_xfer),
		.vx(s_axis_tdata[15:0]), .vy(s_axis_tdata[31:16]), .vz(s_axis_tdata[47:32]),
		.cmd(cmd), .sts(sts), .res_sqx(sqx), .res_sqy(sqy), .res_sqz(sqz),
		.res_dist(mean_dist), .res_rad(rad), .res_cnt(cnt), .res_ovf(ovf)
	);

	assign m_axis_tdata = {6'd0, ovf, cnt, rad, mean_dist, sqz, sqy, sqx};
endmodule
